// ===== design/bfba_pkg.sv =====
// Shared types, widths, codes and defaults for the best-fit block allocator.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps

package bfba_pkg;

    // Field widths of the item and the block table
    localparam int SW = 20;    // block start and payload offset
    localparam int ZW = 21;    // block size, heap end, request bytes
    localparam int TW = 23;    // rounded request plus header, page growth
    localparam int EW = 24;    // heap end plus growth

    // Default configuration
    localparam int DEF_HEAP_CAPACITY = 1048576;
    localparam int DEF_PAGE_BYTES    = 4096;
    localparam int DEF_HEADER_BYTES  = 32;
    localparam int DEF_MIN_PAYLOAD   = 16;
    localparam int DEF_MAX_BLOCKS    = 64;
    localparam int DEF_INITIAL_PAGES = 4;

    // Result status codes
    localparam logic [1:0] RS_OK       = 2'd0;
    localparam logic [1:0] RS_ZERO     = 2'd1;
    localparam logic [1:0] RS_BAD_FREE = 2'd2;
    localparam logic [1:0] RS_NO_MEM   = 2'd3;

    // Item kinds
    localparam logic MODE_ALLOC = 1'b0;

    typedef struct packed {
        logic          used;
        logic [ZW-1:0] size;
        logic [SW-1:0] start;
    } entry_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN_RD,
        CMD_SCAN_EV,
        CMD_GROW,
        CMD_SPLIT_CHK,
        CMD_SHU_RD,
        CMD_SHU_WR,
        CMD_INS_WR,
        CMD_BEST_WR,
        CMD_NXT_RD,
        CMD_NXT_EV,
        CMD_FREE_WR,
        CMD_SHD_RD,
        CMD_SHD_WR,
        CMD_FINISH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [1:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic req_zero;
        logic off_zero;
        logic scan_stop;
        logic scan_last;
        logic found;
        logic grow_over;
        logic last_used;
        logic table_full;
        logic split;
        logic shu_more;
        logic match;
        logic cur_used;
        logic has_next;
        logic shd_more;
        logic out_blocked;
    } dp_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_EV,
        S_ALLOC_CHK,
        S_SPLIT_CHK,
        S_SHU,
        S_SHU_RD,
        S_SHU_WR,
        S_INS_WR,
        S_BEST_WR,
        S_FREE_CHK,
        S_NXT_RD,
        S_NXT_EV,
        S_FREE_WR,
        S_SHD,
        S_SHD_RD,
        S_SHD_WR,
        S_DONE
    } ctrl_state_t;

endpackage

// ===== design/bfba_ctrl.sv =====
// Sequencer of the allocator: walks each item through scan, grow, split and merge.
// Depends on bfba_pkg; drives bfba_dpath through command and status structs.
`timescale 1ns / 1ps

module bfba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    output bfba_pkg::dp_cmd_t    cmd,
    input  bfba_pkg::dp_status_t stat
);
    import bfba_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [1:0]  code_reg, code_next;

    // State and pending status code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= RS_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd.op     = CMD_NONE;
        cmd.code   = code_reg;
        req_stall  = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.is_alloc && stat.req_zero)
                begin
                    code_next  = RS_ZERO;
                    state_next = S_DONE;
                end
                else if (!stat.is_alloc && stat.off_zero)
                begin
                    code_next  = RS_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.op     = CMD_SCAN_RD;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                cmd.op = CMD_SCAN_EV;
                if (stat.scan_stop || stat.scan_last)
                    state_next = stat.is_alloc ? S_ALLOC_CHK : S_FREE_CHK;
                else
                    state_next = S_SCAN_RD;
            end
            S_ALLOC_CHK:
            begin
                if (stat.found)
                begin
                    state_next = S_SPLIT_CHK;
                end
                else if (stat.grow_over || (stat.last_used && stat.table_full))
                begin
                    code_next  = RS_NO_MEM;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = CMD_GROW;
                    state_next = S_SPLIT_CHK;
                end
            end
            S_SPLIT_CHK:
            begin
                cmd.op     = CMD_SPLIT_CHK;
                state_next = S_SHU;
            end
            S_SHU:
            begin
                if (!stat.split)
                    state_next = S_BEST_WR;
                else if (stat.shu_more)
                    state_next = S_SHU_RD;
                else
                    state_next = S_INS_WR;
            end
            S_SHU_RD:
            begin
                cmd.op     = CMD_SHU_RD;
                state_next = S_SHU_WR;
            end
            S_SHU_WR:
            begin
                cmd.op     = CMD_SHU_WR;
                state_next = S_SHU;
            end
            S_INS_WR:
            begin
                cmd.op     = CMD_INS_WR;
                state_next = S_BEST_WR;
            end
            S_BEST_WR:
            begin
                cmd.op     = CMD_BEST_WR;
                code_next  = RS_OK;
                state_next = S_DONE;
            end
            S_FREE_CHK:
            begin
                if (!stat.match || !stat.cur_used)
                begin
                    code_next  = RS_BAD_FREE;
                    state_next = S_DONE;
                end
                else if (stat.has_next)
                begin
                    state_next = S_NXT_RD;
                end
                else
                begin
                    state_next = S_FREE_WR;
                end
            end
            S_NXT_RD:
            begin
                cmd.op     = CMD_NXT_RD;
                state_next = S_NXT_EV;
            end
            S_NXT_EV:
            begin
                cmd.op     = CMD_NXT_EV;
                state_next = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                cmd.op     = CMD_FREE_WR;
                state_next = S_SHD;
            end
            S_SHD:
            begin
                if (stat.shd_more)
                begin
                    state_next = S_SHD_RD;
                end
                else
                begin
                    code_next  = RS_OK;
                    state_next = S_DONE;
                end
            end
            S_SHD_RD:
            begin
                cmd.op     = CMD_SHD_RD;
                state_next = S_SHD_WR;
            end
            S_SHD_WR:
            begin
                cmd.op     = CMD_SHD_WR;
                state_next = S_SHD;
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (!stat.out_blocked)
                begin
                    cmd.op     = CMD_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/bfba_dpath.sv =====
// Datapath of the allocator: block table memory, scan registers, arithmetic, result beat.
// Depends on bfba_pkg; commanded by bfba_ctrl.
`timescale 1ns / 1ps

module bfba_dpath #(
    parameter int HEAP_CAPACITY = bfba_pkg::DEF_HEAP_CAPACITY,
    parameter int PAGE_BYTES    = bfba_pkg::DEF_PAGE_BYTES,
    parameter int HEADER_BYTES  = bfba_pkg::DEF_HEADER_BYTES,
    parameter int MIN_PAYLOAD   = bfba_pkg::DEF_MIN_PAYLOAD,
    parameter int MAX_BLOCKS    = bfba_pkg::DEF_MAX_BLOCKS,
    parameter int INITIAL_PAGES = bfba_pkg::DEF_INITIAL_PAGES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bfba_pkg::dp_cmd_t        cmd,
    output bfba_pkg::dp_status_t     stat,
    input  logic                     mode,
    input  logic [bfba_pkg::ZW-1:0]  request_bytes,
    input  logic [bfba_pkg::SW-1:0]  free_offset,
    input  logic                     rsp_stall,
    output logic                     rsp_valid,
    output logic [bfba_pkg::SW-1:0]  payload_offset,
    output logic [1:0]               status
);
    import bfba_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [TW-1:0] RND7     = TW'(7);
    localparam logic [TW-1:0] HDR_T    = TW'(HEADER_BYTES);
    localparam logic [TW-1:0] SPLIT_T  = TW'(HEADER_BYTES + MIN_PAYLOAD);
    localparam logic [TW-1:0] PAGE_M1  = TW'(PAGE_BYTES - 1);
    localparam logic [ZW-1:0] HDR_Z    = ZW'(HEADER_BYTES);
    localparam logic [SW-1:0] HDR_S    = SW'(HEADER_BYTES);
    localparam logic [ZW-1:0] INIT_SZ  = ZW'(INITIAL_PAGES * PAGE_BYTES);
    localparam logic [EW-1:0] CAP_E    = EW'(HEAP_CAPACITY);
    localparam logic [CW-1:0] MAX_C    = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] ONE_C    = CW'(1);

    // Block table
    entry_t           mem [MAX_BLOCKS];
    logic             we;
    logic [IW-1:0]    waddr, raddr;
    entry_t           wdata;
    entry_t           rd_mem_reg;
    logic             rd_dflt_reg;
    entry_t           rd_entry;

    // Control registers
    logic [CW-1:0]    count_reg, count_next;
    logic [ZW-1:0]    heap_end_reg, heap_end_next;
    logic             e0_reg, e0_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Item and scan registers
    logic             mode_reg, mode_next;
    logic [ZW-1:0]    req_reg, req_next;
    logic [SW-1:0]    off_reg, off_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    best_idx_reg, best_idx_next;
    logic [SW-1:0]    best_start_reg, best_start_next;
    logic [ZW-1:0]    best_size_reg, best_size_next;
    entry_t           last_reg, last_next;
    logic             match_reg, match_next;
    entry_t           cur_reg, cur_next;
    entry_t           prev_reg, prev_next;
    logic             next_free_reg, next_free_next;
    logic [ZW-1:0]    next_size_reg, next_size_next;
    logic             split_reg, split_next;
    logic [CW-1:0]    src_reg, src_next;
    logic [CW-1:0]    dst_reg, dst_next;
    logic [CW-1:0]    end_reg, end_next;
    logic [SW-1:0]    grant_reg, grant_next;
    logic [SW-1:0]    rsp_off_reg, rsp_off_next;
    logic [1:0]       rsp_st_reg, rsp_st_next;

    // Derived values
    logic [TW-1:0]    total, grow, rd_size_t;
    logic [CW-1:0]    idx_c, idx_p1, src_p1;
    logic             cand, exact, match_now, pf, nf;
    logic [ZW-1:0]    merged;
    logic [CW-1:0]    dst_f, src_f;
    logic [1:0]       gap;

    assign total     = ((({2'b00, req_reg}) + RND7) & ~RND7) + HDR_T;
    assign grow      = (total + PAGE_M1) & ~PAGE_M1;
    assign rd_entry  = rd_dflt_reg ? entry_t'{used: 1'b0, size: INIT_SZ, start: '0}
                                   : rd_mem_reg;
    assign rd_size_t = {2'b00, rd_entry.size};
    assign idx_c     = CW'(idx_reg);
    assign idx_p1    = idx_c + ONE_C;
    assign src_p1    = src_reg + ONE_C;

    assign cand      = !rd_entry.used && (rd_size_t >= total) &&
                       (!found_reg || (rd_entry.size < best_size_reg));
    assign exact     = (rd_size_t == total);
    assign match_now = (({1'b0, rd_entry.start}) + HDR_Z) == {1'b0, off_reg};

    // Merge on free: left neighbour, right neighbour, combined size
    assign pf     = (idx_reg != '0) && !prev_reg.used;
    assign nf     = next_free_reg;
    assign merged = cur_reg.size + (nf ? next_size_reg : '0);
    assign gap    = {1'b0, pf} + {1'b0, nf};
    assign dst_f  = pf ? idx_c : idx_p1;
    assign src_f  = dst_f + CW'(gap);

    // Status towards the sequencer
    always_comb
    begin
        stat.is_alloc    = (mode_reg == MODE_ALLOC);
        stat.req_zero    = (req_reg == '0);
        stat.off_zero    = (off_reg == '0);
        stat.scan_stop   = (mode_reg == MODE_ALLOC) ? (cand && exact) : match_now;
        stat.scan_last   = (idx_p1 == count_reg);
        stat.found       = found_reg;
        stat.grow_over   = (EW'(heap_end_reg) + EW'(grow)) > CAP_E;
        stat.last_used   = last_reg.used;
        stat.table_full  = (count_reg >= MAX_C);
        stat.split       = split_reg;
        stat.shu_more    = (src_reg > CW'(best_idx_reg));
        stat.match       = match_reg;
        stat.cur_used    = cur_reg.used;
        stat.has_next    = (idx_p1 < count_reg);
        stat.shd_more    = (src_reg < end_reg);
        stat.out_blocked = rsp_valid_reg && rsp_stall;
    end

    // Command decode
    always_comb
    begin
        count_next      = count_reg;
        heap_end_next   = heap_end_reg;
        e0_next         = e0_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        mode_next       = mode_reg;
        req_next        = req_reg;
        off_next        = off_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_start_next = best_start_reg;
        best_size_next  = best_size_reg;
        last_next       = last_reg;
        match_next      = match_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        next_free_next  = next_free_reg;
        next_size_next  = next_size_reg;
        split_next      = split_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        end_next        = end_reg;
        grant_next      = grant_reg;
        rsp_off_next    = rsp_off_reg;
        rsp_st_next     = rsp_st_reg;
        we              = 1'b0;
        waddr           = best_idx_reg;
        wdata           = rd_entry;
        raddr           = idx_reg;
        case (cmd.op)
            CMD_LOAD:
            begin
                mode_next      = mode;
                req_next       = request_bytes;
                off_next       = free_offset;
                idx_next       = '0;
                found_next     = 1'b0;
                match_next     = 1'b0;
                next_free_next = 1'b0;
                grant_next     = '0;
            end
            CMD_SCAN_RD:
            begin
                raddr = idx_reg;
            end
            CMD_SCAN_EV:
            begin
                if (mode_reg == MODE_ALLOC)
                begin
                    if (cand)
                    begin
                        found_next      = 1'b1;
                        best_idx_next   = idx_reg;
                        best_start_next = rd_entry.start;
                        best_size_next  = rd_entry.size;
                    end
                    last_next = rd_entry;
                    if (!(cand && exact) && !stat.scan_last)
                        idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    if (match_now)
                    begin
                        match_next = 1'b1;
                        cur_next   = rd_entry;
                    end
                    else
                    begin
                        prev_next = rd_entry;
                        if (!stat.scan_last)
                            idx_next = idx_reg + 1'b1;
                    end
                end
            end
            CMD_GROW:
            begin
                // a free last block absorbs the growth, otherwise append one
                if (!last_reg.used)
                begin
                    best_idx_next   = idx_reg;
                    best_start_next = last_reg.start;
                    best_size_next  = last_reg.size + grow[ZW-1:0];
                end
                else
                begin
                    best_idx_next   = count_reg[IW-1:0];
                    best_start_next = heap_end_reg[SW-1:0];
                    best_size_next  = grow[ZW-1:0];
                    count_next      = count_reg + ONE_C;
                end
                heap_end_next = heap_end_reg + grow[ZW-1:0];
            end
            CMD_SPLIT_CHK:
            begin
                split_next = ({2'b00, best_size_reg} >= (total + SPLIT_T)) &&
                             (count_reg < MAX_C);
                src_next   = count_reg - ONE_C;
            end
            CMD_SHU_RD:
            begin
                raddr = src_reg[IW-1:0];
            end
            CMD_SHU_WR:
            begin
                we       = 1'b1;
                waddr    = src_p1[IW-1:0];
                wdata    = rd_entry;
                src_next = src_reg - ONE_C;
            end
            CMD_INS_WR:
            begin
                we          = 1'b1;
                waddr       = best_idx_reg + 1'b1;
                wdata.used  = 1'b0;
                wdata.size  = best_size_reg - total[ZW-1:0];
                wdata.start = best_start_reg + total[SW-1:0];
                count_next  = count_reg + ONE_C;
            end
            CMD_BEST_WR:
            begin
                we          = 1'b1;
                waddr       = best_idx_reg;
                wdata.used  = 1'b1;
                wdata.size  = split_reg ? total[ZW-1:0] : best_size_reg;
                wdata.start = best_start_reg;
                grant_next  = best_start_reg + HDR_S;
            end
            CMD_NXT_RD:
            begin
                raddr = idx_p1[IW-1:0];
            end
            CMD_NXT_EV:
            begin
                next_free_next = !rd_entry.used;
                next_size_next = rd_entry.size;
            end
            CMD_FREE_WR:
            begin
                we = 1'b1;
                if (pf)
                begin
                    waddr       = idx_reg - 1'b1;
                    wdata.used  = 1'b0;
                    wdata.size  = prev_reg.size + merged;
                    wdata.start = prev_reg.start;
                end
                else
                begin
                    waddr       = idx_reg;
                    wdata.used  = 1'b0;
                    wdata.size  = merged;
                    wdata.start = cur_reg.start;
                end
                dst_next   = dst_f;
                src_next   = src_f;
                end_next   = (gap != 2'd0) ? count_reg : src_f;
                count_next = count_reg - CW'(gap);
            end
            CMD_SHD_RD:
            begin
                raddr = src_reg[IW-1:0];
            end
            CMD_SHD_WR:
            begin
                we       = 1'b1;
                waddr    = dst_reg[IW-1:0];
                wdata    = rd_entry;
                src_next = src_reg + ONE_C;
                dst_next = dst_reg + ONE_C;
            end
            CMD_FINISH:
            begin
                rsp_valid_next = 1'b1;
                rsp_st_next    = cmd.code;
                rsp_off_next   = grant_reg;
            end
            default:
            begin
                raddr = idx_reg;
            end
        endcase
        if (we && (waddr == '0))
            e0_next = 1'b1;
    end

    // Table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_mem_reg <= mem[raddr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= ONE_C;
            heap_end_reg  <= INIT_SZ;
            e0_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rd_dflt_reg   <= 1'b1;
        end
        else
        begin
            count_reg     <= count_next;
            heap_end_reg  <= heap_end_next;
            e0_reg        <= e0_next;
            rsp_valid_reg <= rsp_valid_next;
            rd_dflt_reg   <= !e0_reg && (raddr == '0);
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        req_reg        <= req_next;
        off_reg        <= off_next;
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_start_reg <= best_start_next;
        best_size_reg  <= best_size_next;
        last_reg       <= last_next;
        match_reg      <= match_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        next_free_reg  <= next_free_next;
        next_size_reg  <= next_size_next;
        split_reg      <= split_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        end_reg        <= end_next;
        grant_reg      <= grant_next;
        rsp_off_reg    <= rsp_off_next;
        rsp_st_reg     <= rsp_st_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign payload_offset = rsp_off_reg;
    assign status         = rsp_st_reg;

    // Checks on table bookkeeping
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= ONE_C) && (count_reg <= MAX_C))
        else $error("block count out of range");

    a_heap_limit: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(heap_end_reg) <= CAP_E)
        else $error("heap end beyond capacity");

    a_best_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_BEST_WR) |-> (CW'(best_idx_reg) < count_reg))
        else $error("granted block outside the table");

    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == CMD_FINISH) && (cmd.code != RS_OK)) |=> (payload_offset == '0))
        else $error("failed item carries a payload offset");

endmodule

// ===== design/best_fit_block_allocator.sv =====
// Top level of the best-fit block allocator: sequencer plus datapath.
// Depends on bfba_pkg, bfba_ctrl and bfba_dpath.
//
//   channel   handshake            payload
//   request   req_valid/req_stall  mode, request_bytes, free_offset
//   result    rsp_valid/rsp_stall  payload_offset, status
//
// One item at a time. An allocate scans table entries, moves entries up on a
// split and writes the granted block; a free scans entries up to its block and
// moves entries down on a merge. The single table read port sets the pace.
// Reset needs no clearing pass: entry 0 reads as the initial block until written.
// A stalled result beat holds in its register; the next item is taken meanwhile.
`timescale 1ns / 1ps

module best_fit_block_allocator #(
    parameter int HEAP_CAPACITY = bfba_pkg::DEF_HEAP_CAPACITY,
    parameter int PAGE_BYTES    = bfba_pkg::DEF_PAGE_BYTES,
    parameter int HEADER_BYTES  = bfba_pkg::DEF_HEADER_BYTES,
    parameter int MIN_PAYLOAD   = bfba_pkg::DEF_MIN_PAYLOAD,
    parameter int MAX_BLOCKS    = bfba_pkg::DEF_MAX_BLOCKS,
    parameter int INITIAL_PAGES = bfba_pkg::DEF_INITIAL_PAGES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic                     mode,
    input  logic [bfba_pkg::ZW-1:0]  request_bytes,
    input  logic [bfba_pkg::SW-1:0]  free_offset,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic [bfba_pkg::SW-1:0]  payload_offset,
    output logic [1:0]               status
);
    import bfba_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    // Sequencer
    bfba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Table and arithmetic
    bfba_dpath #(
        .HEAP_CAPACITY (HEAP_CAPACITY),
        .PAGE_BYTES    (PAGE_BYTES),
        .HEADER_BYTES  (HEADER_BYTES),
        .MIN_PAYLOAD   (MIN_PAYLOAD),
        .MAX_BLOCKS    (MAX_BLOCKS),
        .INITIAL_PAGES (INITIAL_PAGES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .mode           (mode),
        .request_bytes  (request_bytes),
        .free_offset    (free_offset),
        .rsp_stall      (rsp_stall),
        .rsp_valid      (rsp_valid),
        .payload_offset (payload_offset),
        .status         (status)
    );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for best_fit_block_allocator: directed table, then random traffic.
// Depends on bfba_pkg and the allocator RTL; holds its own block table model for prediction.
`timescale 1ns / 1ps

module tb_top;
    import bfba_pkg::*;

    localparam logic MODE_FREE  = 1'b1;
    localparam int   HDR        = DEF_HEADER_BYTES;
    localparam int   MAXB       = DEF_MAX_BLOCKS;
    localparam int   N_RANDOM   = 830;
    localparam int   CYCLE_CAP  = 1000000;
    localparam int   DRAIN_WAIT = 300;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    logic          mode = MODE_ALLOC;
    logic [ZW-1:0] request_bytes = '0;
    logic [SW-1:0] free_offset = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    logic [SW-1:0] payload_offset;
    logic [1:0]    status;

    typedef struct {
        logic [SW-1:0] offset;
        logic [1:0]    code;
    } grant_t;

    typedef struct {
        logic          m;
        logic [ZW-1:0] req;
        logic [SW-1:0] off;
        bit            typed;
        logic [SW-1:0] exp_off;
        logic [1:0]    exp_code;
    } row_t;

    // Heap table model
    longint tab_start [MAXB];
    longint tab_size  [MAXB];
    bit     tab_used  [MAXB];
    int     tab_count;
    longint heap_top;

    grant_t pending_grants[$];
    int     live_offsets[$];
    int     mismatches = 0;
    int     cycles = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;

    best_fit_block_allocator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .mode           (mode),
        .request_bytes  (request_bytes),
        .free_offset    (free_offset),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .payload_offset (payload_offset),
        .status         (status)
    );

    always #5 clk = ~clk;

    // Open a slot at pos for a new free block
    function automatic void slot_open(int pos, longint st, longint sz);
        for (int k = tab_count; k > pos; k--)
        begin
            tab_start[k] = tab_start[k-1];
            tab_size[k]  = tab_size[k-1];
            tab_used[k]  = tab_used[k-1];
        end
        tab_start[pos] = st;
        tab_size[pos]  = sz;
        tab_used[pos]  = 1'b0;
        tab_count++;
    endfunction

    // Close the slot at pos
    function automatic void slot_close(int pos);
        for (int k = pos; k + 1 < tab_count; k++)
        begin
            tab_start[k] = tab_start[k+1];
            tab_size[k]  = tab_size[k+1];
            tab_used[k]  = tab_used[k+1];
        end
        tab_count--;
    endfunction

    function automatic grant_t heap_alloc(longint req);
        grant_t g;
        longint total;
        longint grow;
        longint best_sz;
        int     best;
        bit     found;
        g.offset = '0;
        g.code   = RS_OK;
        found    = 1'b0;
        best     = 0;
        best_sz  = 0;
        if (req == 0)
        begin
            g.code = RS_ZERO;
            return g;
        end
        total = ((req + 7) & ~longint'(7)) + HDR;
        // Smallest fit wins, exact fit ends the scan
        for (int i = 0; i < tab_count; i++)
        begin
            if (!tab_used[i] && tab_size[i] >= total && (!found || tab_size[i] < best_sz))
            begin
                found   = 1'b1;
                best    = i;
                best_sz = tab_size[i];
                if (tab_size[i] == total)
                    break;
            end
        end
        if (!found)
        begin
            grow = (total + DEF_PAGE_BYTES - 1) / DEF_PAGE_BYTES * DEF_PAGE_BYTES;
            if (heap_top + grow > DEF_HEAP_CAPACITY)
            begin
                g.code = RS_NO_MEM;
                return g;
            end
            if (!tab_used[tab_count-1])
            begin
                tab_size[tab_count-1] += grow;
                best = tab_count - 1;
            end
            else
            begin
                if (tab_count >= MAXB)
                begin
                    g.code = RS_NO_MEM;
                    return g;
                end
                slot_open(tab_count, heap_top, grow);
                best = tab_count - 1;
            end
            heap_top += grow;
        end
        if (tab_size[best] >= total + HDR + DEF_MIN_PAYLOAD && tab_count < MAXB)
        begin
            slot_open(best + 1, tab_start[best] + total, tab_size[best] - total);
            tab_size[best] = total;
        end
        tab_used[best] = 1'b1;
        g.offset = SW'(tab_start[best] + HDR);
        return g;
    endfunction

    function automatic logic [1:0] heap_release(longint off);
        int i;
        if (off == 0)
            return RS_OK;
        for (i = 0; i < tab_count; i++)
        begin
            if (tab_start[i] + HDR == off)
                break;
        end
        if (i >= tab_count || !tab_used[i])
            return RS_BAD_FREE;
        tab_used[i] = 1'b0;
        // Merge right, then left
        if (i + 1 < tab_count && !tab_used[i+1])
        begin
            tab_size[i] += tab_size[i+1];
            slot_close(i + 1);
        end
        if (i > 0 && !tab_used[i-1])
        begin
            tab_size[i-1] += tab_size[i];
            slot_close(i);
        end
        return RS_OK;
    endfunction

    function automatic void heap_clear();
        tab_start[0] = 0;
        tab_size[0]  = DEF_INITIAL_PAGES * DEF_PAGE_BYTES;
        tab_used[0]  = 1'b0;
        tab_count    = 1;
        heap_top     = DEF_INITIAL_PAGES * DEF_PAGE_BYTES;
    endfunction

    // Drive one beat, hold until taken, then update the model and live list
    task automatic send_beat(row_t r);
        grant_t g;
        req_valid     <= 1'b1;
        mode          <= r.m;
        request_bytes <= r.req;
        free_offset   <= r.off;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        if (r.m == MODE_ALLOC)
        begin
            g = heap_alloc(r.req);
            if (g.code == RS_OK)
                live_offsets.push_back(g.offset);
        end
        else
        begin
            g.offset = '0;
            g.code   = heap_release(r.off);
            if (g.code == RS_OK && r.off != 0)
            begin
                foreach (live_offsets[k])
                begin
                    if (live_offsets[k] == r.off)
                    begin
                        live_offsets.delete(k);
                        break;
                    end
                end
            end
        end
        if (r.typed)
        begin
            g.offset = r.exp_off;
            g.code   = r.exp_code;
        end
        pending_grants.push_back(g);
        // Sender gap
        if ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic row_t random_row(int idx);
        row_t r;
        int   pick;
        int   alloc_pct;
        r.typed    = 1'b0;
        r.exp_off  = '0;
        r.exp_code = RS_OK;
        r.req      = ZW'($urandom);
        r.off      = SW'($urandom);
        // Alternate alloc-heavy and free-heavy stretches to fill and drain the table
        alloc_pct = ((idx / 100) % 2 == 0) ? 75 : 35;
        if ($urandom_range(99) < alloc_pct)
        begin
            r.m  = MODE_ALLOC;
            pick = $urandom_range(99);
            if (pick < 70)
                r.req = ZW'($urandom_range(1, 256));
            else if (pick < 90)
                r.req = ZW'($urandom_range(257, 20000));
            else if (pick < 97)
                r.req = ZW'($urandom_range(20001, 300000));
            else if (pick == 97)
                r.req = '0;
        end
        else
        begin
            r.m  = MODE_FREE;
            pick = $urandom_range(99);
            if (live_offsets.size() > 0 && pick < 85)
                r.off = SW'(live_offsets[$urandom_range(live_offsets.size() - 1)]);
            else if (pick < 90)
                r.off = '0;
            else if (live_offsets.size() > 0 && pick < 95)
                r.off = SW'(live_offsets[0] + 8);
        end
        return r;
    endfunction

    // Receiver stall
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < rx_idle_pct);

    // Check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: offset %0d status %0d",
                             payload_offset, status);
            end
            else
            begin
                g = pending_grants.pop_front();
                if (payload_offset !== g.offset || status !== g.code)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected offset %0d status %0d, got %0d %0d",
                                 g.offset, g.code, payload_offset, status);
                end
            end
        end
    end

    // Give up on a hang
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("FAIL best_fit_block_allocator");
            $finish;
        end
    end

    initial
    begin
        row_t directed[$];
        int   idx;
        int   wait_cycles;
        heap_clear();
        // Rows: mode, request, offset, typed, expected offset, expected status
        directed = '{
            '{MODE_ALLOC, 21'd1,       20'd0,       1'b1, 20'd32, RS_OK},
            '{MODE_ALLOC, 21'd0,       20'd0,       1'b1, 20'd0,  RS_ZERO},
            '{MODE_FREE,  21'd0,       20'd0,       1'b1, 20'd0,  RS_OK},
            '{MODE_FREE,  21'd0,       20'd5,       1'b1, 20'd0,  RS_BAD_FREE},
            '{MODE_ALLOC, 21'h1FFFFF,  20'd0,       1'b1, 20'd0,  RS_NO_MEM},
            '{MODE_ALLOC, 21'd1048576, 20'd0,       1'b1, 20'd0,  RS_NO_MEM},
            '{MODE_ALLOC, 21'd8,       20'd0,       1'b0, 20'd0,  RS_OK},
            '{MODE_ALLOC, 21'd16000,   20'd0,       1'b0, 20'd0,  RS_OK},
            '{MODE_FREE,  21'd0,       20'd32,      1'b0, 20'd0,  RS_OK},
            '{MODE_FREE,  21'd0,       20'd32,      1'b1, 20'd0,  RS_BAD_FREE},
            '{MODE_ALLOC, 21'd20000,   20'd0,       1'b0, 20'd0,  RS_OK},
            '{MODE_ALLOC, 21'd1,       20'd0,       1'b0, 20'd0,  RS_OK},
            '{MODE_FREE,  21'd0,       20'hFFFFF,   1'b1, 20'd0,  RS_BAD_FREE},
            '{MODE_ALLOC, 21'd7,       20'd0,       1'b0, 20'd0,  RS_OK},
            '{MODE_FREE,  21'd0,       20'd72,      1'b0, 20'd0,  RS_OK},
            '{MODE_ALLOC, 21'd1000000, 20'd0,       1'b0, 20'd0,  RS_OK},
            '{MODE_ALLOC, 21'd900000,  20'd0,       1'b0, 20'd0,  RS_OK},
            '{MODE_ALLOC, 21'd4000,    20'd0,       1'b0, 20'd0,  RS_OK},
            '{MODE_FREE,  21'd0,       20'd8,       1'b0, 20'd0,  RS_OK},
            '{MODE_ALLOC, 21'd16,      20'd0,       1'b0, 20'd0,  RS_OK}
        };

        // Hold reset, then release once
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 22;
        rx_idle_pct = 47;
        foreach (directed[i])
            send_beat(directed[i]);

        for (idx = 0; idx < N_RANDOM; idx++)
        begin
            // Swap idle rates, then run flat out
            if (idx == 280)
            begin
                tx_idle_pct = 47;
                rx_idle_pct = 22;
            end
            else if (idx == 560)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // Pause the sender until the pipe drains
            if (idx == 200 || idx == 600)
            begin
                req_valid <= 1'b0;
                while (pending_grants.size() > 0)
                    @(posedge clk);
            end
            send_beat(random_row(idx));
        end
        req_valid <= 1'b0;

        // Drain, then allow for a late extra beat
        wait_cycles = 0;
        while (pending_grants.size() > 0)
            @(posedge clk);
        while (wait_cycles < DRAIN_WAIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        if (mismatches == 0 && pending_grants.size() == 0)
            $display("PASS best_fit_block_allocator");
        else
            $display("FAIL best_fit_block_allocator");
        $finish;
    end

endmodule
